// ===== rtl/u8lc_pkg.sv =====
// shared types and helpers of the utf-8 lowercase transcoder
// run entry passed from front to back, lead byte classes, case lowering
// no dependencies
`default_nettype none

package u8lc_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] CP_ASCII_UP_LO = 21'h00041;
  localparam logic [CP_W-1:0] CP_ASCII_UP_HI = 21'h0005A;
  localparam logic [CP_W-1:0] CP_CYR_UP_LO   = 21'h00410;
  localparam logic [CP_W-1:0] CP_CYR_UP_HI   = 21'h0042F;
  localparam logic [CP_W-1:0] CP_IO_UP       = 21'h00401;
  localparam logic [CP_W-1:0] CP_IO_LOW      = 21'h00451;
  localparam logic [CP_W-1:0] CP_CASE_OFS    = 21'h00020;

  localparam logic [CP_W-1:0] CP_MAX_1B = 21'h0007F;
  localparam logic [CP_W-1:0] CP_MAX_2B = 21'h007FF;
  localparam logic [CP_W-1:0] CP_MAX_3B = 21'h0FFFF;

  localparam logic [7:0] LEAD_2B  = 8'hC0;
  localparam logic [7:0] LEAD_3B  = 8'hE0;
  localparam logic [7:0] LEAD_4B  = 8'hF0;
  localparam logic [7:0] CONT_TAG = 8'h80;

  typedef logic [CP_W-1:0] cp_t;

  // buffered bytes of one run, lead byte in entry 0
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
    logic            last;
  } run_t;

  // continuation bytes called for by a lead byte, zero for single or invalid
  function automatic logic [1:0] lead_extra(input logic [7:0] b);
    logic [1:0] e;
    e = 2'd0;
    if (b[7:5] == 3'b110) e = 2'd1;
    else if (b[7:4] == 4'b1110) e = 2'd2;
    else if (b[7:3] == 5'b11110) e = 2'd3;
    return e;
  endfunction

  function automatic cp_t lower_cp(input cp_t cp);
    cp_t r;
    r = cp;
    if (cp >= CP_ASCII_UP_LO && cp <= CP_ASCII_UP_HI) r = cp + CP_CASE_OFS;
    else if (cp >= CP_CYR_UP_LO && cp <= CP_CYR_UP_HI) r = cp + CP_CASE_OFS;
    else if (cp == CP_IO_UP) r = CP_IO_LOW;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/u8lc_front.sv =====
// front end: accepts input bytes, buffers open sequences, emits runs when complete or at string end
// depends on u8lc_pkg
`default_nettype none

module u8lc_front
  import u8lc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  input  wire logic       string_end,
  output logic            push,
  output run_t            push_run
);

  logic [7:0] pend_r [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic [2:0] seqlen_r, seqlen_nxt;
  logic [2:0] run_len;
  logic       complete;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (i < 3 && 2'(i) < cnt_r) push_run.bytes[i] = pend_r[(i < 3) ? i : 0];
      else if (2'(i) == cnt_r) push_run.bytes[i] = in_byte;
      else push_run.bytes[i] = 8'h00;
    end
    run_len       = {1'b0, cnt_r} + 3'd1;
    push_run.len  = run_len;
    push_run.last = string_end;
    if (cnt_r == 2'd0) complete = (lead_extra(in_byte) == 2'd0);
    else complete = (run_len >= seqlen_r);
    push = accept && (string_end || complete);
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    seqlen_nxt = seqlen_r;
    if (accept) begin
      if (push) begin
        cnt_nxt    = 2'd0;
        seqlen_nxt = 3'd0;
      end else if (cnt_r == 2'd0) begin
        cnt_nxt    = 2'd1;
        seqlen_nxt = {1'b0, lead_extra(in_byte)} + 3'd1;
      end else if (cnt_r != 2'd3) begin
        cnt_nxt = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      seqlen_r <= 3'd0;
    end else begin
      cnt_r    <= cnt_nxt;
      seqlen_r <= seqlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (accept && !push && cnt_r == 2'(i)) pend_r[i] <= in_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u8lc_queue.sv =====
// short queue of runs between front and back end
// depends on u8lc_pkg
`default_nettype none

module u8lc_queue
  import u8lc_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  run_t      push_run,
  input  wire logic pop,
  output logic      not_full,
  output logic      head_valid,
  output run_t      head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  run_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign not_full   = (count_r != CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) count_r <= count_r + 1'b1;
      else if (!push && do_pop) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_run;
  end

endmodule

`default_nettype wire

// ===== rtl/u8lc_back.sv =====
// back end: decodes code points of the head run, lowers, re-encodes
// one output byte per cycle while a run is queued and out_tready allows, through a registered output stage
// depends on u8lc_pkg
`default_nettype none

module u8lc_back
  import u8lc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  run_t            head,
  output logic            pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            output_end
);

  logic [1:0] pos_r, pos_nxt;
  logic [1:0] bidx_r, bidx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       run_last_r;
  logic       out_end_r;

  logic [7:0]      b0, b1, b2, b3;
  logic [1:0]      extra;
  logic [2:0]      consumed, next_pos;
  cp_t             cp, lcp;
  logic [3:0][7:0] enc;
  logic [1:0]      enc_last;
  logic            load_ok, emit, cp_done, run_done;

  always_comb begin
    b0    = head.bytes[pos_r];
    b1    = head.bytes[pos_r + 2'd1];
    b2    = head.bytes[pos_r + 2'd2];
    b3    = head.bytes[pos_r + 2'd3];
    extra = lead_extra(b0);
    if (extra != 2'd0 && ({1'b0, pos_r} + {1'b0, extra}) < head.len) begin
      consumed = {1'b0, extra} + 3'd1;
      case (extra)
        2'd1:    cp = CP_W'({b0[4:0], b1[5:0]});
        2'd2:    cp = CP_W'({b0[3:0], b1[5:0], b2[5:0]});
        2'd3:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        default: cp = CP_W'(b0);
      endcase
    end else begin
      consumed = 3'd1;
      cp       = CP_W'(b0);
    end
    lcp = lower_cp(cp);

    enc = '0;
    if (lcp <= CP_MAX_1B) begin
      enc[0]   = lcp[7:0];
      enc_last = 2'd0;
    end else if (lcp <= CP_MAX_2B) begin
      enc[0]   = LEAD_2B | {3'b000, lcp[10:6]};
      enc[1]   = CONT_TAG | {2'b00, lcp[5:0]};
      enc_last = 2'd1;
    end else if (lcp <= CP_MAX_3B) begin
      enc[0]   = LEAD_3B | {4'b0000, lcp[15:12]};
      enc[1]   = CONT_TAG | {2'b00, lcp[11:6]};
      enc[2]   = CONT_TAG | {2'b00, lcp[5:0]};
      enc_last = 2'd2;
    end else begin
      enc[0]   = LEAD_4B | {5'b00000, lcp[20:18]};
      enc[1]   = CONT_TAG | {2'b00, lcp[17:12]};
      enc[2]   = CONT_TAG | {2'b00, lcp[11:6]};
      enc[3]   = CONT_TAG | {2'b00, lcp[5:0]};
      enc_last = 2'd3;
    end

    next_pos = {1'b0, pos_r} + consumed;
    cp_done  = (bidx_r == enc_last);
    run_done = cp_done && (next_pos == head.len);
    load_ok  = !out_valid_r || out_tready;
    emit     = head_valid && load_ok;
    pop      = emit && run_done;

    pos_nxt       = pos_r;
    bidx_nxt      = bidx_r;
    out_valid_nxt = out_valid_r;
    if (load_ok) out_valid_nxt = head_valid;
    if (emit) begin
      if (cp_done) begin
        bidx_nxt = 2'd0;
        pos_nxt  = run_done ? 2'd0 : next_pos[1:0];
      end else begin
        bidx_nxt = bidx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 2'd0;
      bidx_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      bidx_r      <= bidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= enc[bidx_r];
      run_last_r <= run_done;
      out_end_r  <= run_done && head.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_byte   = out_byte_r;
  assign run_last   = run_last_r;
  assign output_end = out_end_r;

endmodule

`default_nettype wire

// ===== rtl/utf8_lowercase_transcoder.sv =====
// utf-8 lowercase transcoder, top level: front end, run queue, back end
// path: a run-completing byte is written into the queue, then its first output byte into the output register
// throughput: one input byte per cycle and one output byte per cycle; input stalls only once
// the queue fills, while runs expand (lone leads, invalid bytes) or out_tready is held low
// reset: synchronous active-low rst_n empties the queue and drops any buffered sequence
// depends on u8lc_pkg, u8lc_front, u8lc_queue, u8lc_back
`default_nettype none

module utf8_lowercase_transcoder
  import u8lc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // string_end
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tuser,  // run_last
  output logic            out_tlast   // output_end
);

  logic accept;
  logic push;
  run_t push_run;
  logic pop;
  logic not_full;
  logic head_valid;
  run_t head;

  assign in_tready = not_full;
  assign accept    = in_tvalid && not_full;

  u8lc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_byte    (in_tdata),
    .string_end (in_tlast),
    .push       (push),
    .push_run   (push_run)
  );

  u8lc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_run   (push_run),
    .pop        (pop),
    .not_full   (not_full),
    .head_valid (head_valid),
    .head       (head)
  );

  u8lc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .run_last   (out_tuser),
    .output_end (out_tlast)
  );

endmodule

`default_nettype wire
